// ===== design/usbcdp_pkg.sv =====
// Shared types and constants for the USB configuration descriptor parser.
package usbcdp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EPNUM_W = 4;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [BYTE_W-1:0] TYPE_ENDPOINT  = 8'd5;
  localparam logic [BYTE_W-1:0] TYPE_INTERFACE = 8'd4;
  localparam logic [BYTE_W-1:0] ATTR_BULK      = 8'd2;
  localparam logic [BYTE_W-1:0] HEADER_BYTES   = 8'd2;
  localparam logic [BYTE_W-1:0] MIN_EP_LENGTH  = 8'd6;
  localparam logic [BYTE_W-1:0] MIN_IF_LENGTH  = 8'd3;
  localparam logic [BYTE_W-1:0] EP_NUM_MASK    = 8'h0f;
  localparam int unsigned       DIR_IN_BIT     = 7;
  localparam logic [SIZE_W-1:0] DEFAULT_PACKET = 16'd64;

  // Byte positions inside one descriptor.
  localparam logic [BYTE_W-1:0] OFF_LENGTH  = 8'd0;
  localparam logic [BYTE_W-1:0] OFF_TYPE    = 8'd1;
  localparam logic [BYTE_W-1:0] OFF_ADDRESS = 8'd2;
  localparam logic [BYTE_W-1:0] OFF_ATTR    = 8'd3;
  localparam logic [BYTE_W-1:0] OFF_SIZE_LO = 8'd4;
  localparam logic [BYTE_W-1:0] OFF_SIZE_HI = 8'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  interface_number;
    logic [SIZE_W-1:0]  out_max_packet;
    logic [SIZE_W-1:0]  in_max_packet;
    logic [EPNUM_W-1:0] bulk_out_endpoint;
    logic [EPNUM_W-1:0] bulk_in_endpoint;
    logic               found;
  } result_t;

endpackage

// ===== design/usbcdp_in_stage.sv =====
// Input register stage holding one received byte until the walker takes it.
module usbcdp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  usbcdp_pkg::in_item_t in_item,
  input  logic                 take,
  output logic                 item_valid,
  output usbcdp_pkg::in_item_t item
);
  import usbcdp_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/usbcdp_walker.sv =====
// Descriptor walker: per-byte update of the walk state and the captured endpoint values.
module usbcdp_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  usbcdp_pkg::in_item_t item,
  output usbcdp_pkg::result_t  result
);
  import usbcdp_pkg::*;

  logic [BYTE_W-1:0]  off_r, off_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  type_r, type_nxt;
  logic [BYTE_W-1:0]  addr_r, addr_nxt;
  logic [BYTE_W-1:0]  attr_r, attr_nxt;
  logic [SIZE_W-1:0]  psize_r, psize_nxt;
  logic [BYTE_W-1:0]  iface_r, iface_nxt;
  logic               stopped_r, stopped_nxt;
  logic [EPNUM_W-1:0] in_ep_r, in_ep_nxt;
  logic [EPNUM_W-1:0] out_ep_r, out_ep_nxt;
  logic [SIZE_W-1:0]  in_size_r, in_size_nxt;
  logic [SIZE_W-1:0]  out_size_r, out_size_nxt;
  logic [BYTE_W-1:0]  iface_kept_r, iface_kept_nxt;

  logic [BYTE_W-1:0]  b;
  logic               desc_done;
  logic [BYTE_W:0]    off_plus1;
  logic [BYTE_W-1:0]  ep_masked;

  assign b         = item.data_byte;
  assign off_plus1 = {1'b0, off_r} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    off_nxt        = off_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    addr_nxt       = addr_r;
    attr_nxt       = attr_r;
    psize_nxt      = psize_r;
    iface_nxt      = iface_r;
    stopped_nxt    = stopped_r;
    in_ep_nxt      = in_ep_r;
    out_ep_nxt     = out_ep_r;
    in_size_nxt    = in_size_r;
    out_size_nxt   = out_size_r;
    iface_kept_nxt = iface_kept_r;
    desc_done      = 1'b0;
    ep_masked      = '0;

    if (!stopped_r) begin
      case (off_r)
        OFF_LENGTH:  len_nxt = b;
        OFF_TYPE:    type_nxt = b;
        OFF_ADDRESS: begin
          addr_nxt  = b;
          iface_nxt = b;
        end
        OFF_ATTR:    attr_nxt = b;
        OFF_SIZE_LO: psize_nxt = {psize_r[SIZE_W-1:BYTE_W], b};
        OFF_SIZE_HI: psize_nxt = {b, psize_r[BYTE_W-1:0]};
        default:     ;
      endcase

      if ((off_r == OFF_LENGTH) && (b < HEADER_BYTES)) begin
        // A length too small to hold its own header ends the walk for this blob.
        stopped_nxt = 1'b1;
      end else begin
        desc_done = off_plus1 >= {1'b0, len_nxt};
        off_nxt   = desc_done ? '0 : off_plus1[BYTE_W-1:0];
      end

      // A descriptor takes effect on its final byte, using that byte's update too.
      if (desc_done) begin
        ep_masked = addr_nxt & EP_NUM_MASK;
        if ((type_nxt == TYPE_ENDPOINT) && (len_nxt >= MIN_EP_LENGTH)) begin
          if (attr_nxt == ATTR_BULK) begin
            if (addr_nxt[DIR_IN_BIT]) begin
              in_ep_nxt   = ep_masked[EPNUM_W-1:0];
              in_size_nxt = psize_nxt;
            end else begin
              out_ep_nxt   = ep_masked[EPNUM_W-1:0];
              out_size_nxt = psize_nxt;
            end
          end
        end else if ((type_nxt == TYPE_INTERFACE) && (len_nxt >= MIN_IF_LENGTH)) begin
          iface_kept_nxt = iface_nxt;
        end
      end
    end
  end

  always_comb begin
    result.found             = (in_ep_nxt != '0) || (out_ep_nxt != '0);
    result.bulk_in_endpoint  = in_ep_nxt;
    result.bulk_out_endpoint = out_ep_nxt;
    result.in_max_packet     = in_size_nxt;
    result.out_max_packet    = out_size_nxt;
    result.interface_number  = iface_kept_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && item.last_byte)) begin
      off_r        <= '0;
      len_r        <= '0;
      type_r       <= '0;
      addr_r       <= '0;
      attr_r       <= '0;
      psize_r      <= '0;
      iface_r      <= '0;
      stopped_r    <= 1'b0;
      in_ep_r      <= '0;
      out_ep_r     <= '0;
      in_size_r    <= DEFAULT_PACKET;
      out_size_r   <= DEFAULT_PACKET;
      iface_kept_r <= '0;
    end else if (take) begin
      off_r        <= off_nxt;
      len_r        <= len_nxt;
      type_r       <= type_nxt;
      addr_r       <= addr_nxt;
      attr_r       <= attr_nxt;
      psize_r      <= psize_nxt;
      iface_r      <= iface_nxt;
      stopped_r    <= stopped_nxt;
      in_ep_r      <= in_ep_nxt;
      out_ep_r     <= out_ep_nxt;
      in_size_r    <= in_size_nxt;
      out_size_r   <= out_size_nxt;
      iface_kept_r <= iface_kept_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stop_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (off_r == '0))
    else $error("walk stopped away from a descriptor start");

  a_off_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (off_r != '0) |-> (off_r < len_r))
    else $error("descriptor offset beyond its length");

  a_blob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.last_byte) |=>
      (!stopped_r && (off_r == '0) && (in_size_r == DEFAULT_PACKET) &&
       (out_size_r == DEFAULT_PACKET) && (in_ep_r == '0) && (out_ep_r == '0)))
    else $error("state not cleared after the last byte of a blob");
`endif

endmodule

// ===== design/usbcdp_out_reg.sv =====
// Result register that holds one report until the downstream side takes it.
module usbcdp_out_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  usbcdp_pkg::result_t            result,
  output logic                           slot_free,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [usbcdp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import usbcdp_pkg::*;

  localparam int unsigned PAD_W = OUT_TDATA_W - $bits(result_t);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign slot_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, data_r};

endmodule

// ===== design/usb_config_descriptor_parser_top.sv =====
// Top level of the USB configuration descriptor bulk endpoint parser.
// Bytes of a configuration descriptor blob enter one per transaction on the
// in_ channel, with in_tlast on the final byte. Each byte passes an input
// register and is folded into the walk state as it leaves that register; a new
// byte is taken every cycle, one byte per clock, unless a last byte must wait
// there for room in the report register. Only the last byte of a blob yields a
// report on the out_ channel. The report is loaded on the same edge at which
// that byte leaves the input register. The report register holds it under
// backpressure while later bytes keep flowing until another report is due.
// After each report all captured values return to their defaults (no endpoint,
// max packet 64, interface 0) for the next blob.
module usb_config_descriptor_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] found, [4:1] bulk_in_endpoint, [8:5] bulk_out_endpoint,
  // [24:9] in_max_packet, [40:25] out_max_packet, [48:41] interface_number, [55:49] zero
  output logic [55:0] out_tdata
);
  import usbcdp_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     slot_free;
  logic     take;
  result_t  result;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  // A last byte can only proceed when the report register has room.
  assign take = item_valid && (!item.last_byte || slot_free);

  usbcdp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  usbcdp_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .result (result)
  );

  usbcdp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && item.last_byte),
    .result     (result),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the USB configuration descriptor bulk endpoint parser.
module tb;
  import usbcdp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [BYTE_W-1:0] DESC_CONFIG = 8'd2;
  localparam int FULL_SPAN = 256;

  typedef struct {
    logic [BYTE_W-1:0]  pos;
    logic [BYTE_W-1:0]  dlen;
    logic [BYTE_W-1:0]  dtype;
    logic [BYTE_W-1:0]  addr;
    logic [BYTE_W-1:0]  attr;
    logic [SIZE_W-1:0]  psize;
    logic [BYTE_W-1:0]  ifnum;
    logic               stopped;
    logic [EPNUM_W-1:0] in_ep;
    logic [EPNUM_W-1:0] out_ep;
    logic [SIZE_W-1:0]  in_sz;
    logic [SIZE_W-1:0]  out_sz;
    logic [BYTE_W-1:0]  if_kept;
  } walk_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  walk_state_t       walk;
  result_t           expected_reports[$];
  logic [BYTE_W-1:0] blob_bytes[$];
  result_t           got_report;
  result_t           want_report;
  int                mismatch_count = 0;
  int                report_index = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                cycle_count = 0;

  usb_config_descriptor_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_walk();
    walk.pos     = '0;
    walk.dlen    = '0;
    walk.dtype   = '0;
    walk.addr    = '0;
    walk.attr    = '0;
    walk.psize   = '0;
    walk.ifnum   = '0;
    walk.stopped = 1'b0;
    walk.in_ep   = '0;
    walk.out_ep  = '0;
    walk.in_sz   = DEFAULT_PACKET;
    walk.out_sz  = DEFAULT_PACKET;
    walk.if_kept = '0;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Folds one accepted byte into the walk; returns 1 when a report is due.
  function automatic bit track_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    output result_t rpt);
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] ep_num;
    pos = walk.pos;
    rpt = '0;
    if (!walk.stopped) begin
      case (pos)
        OFF_LENGTH:  walk.dlen = b;
        OFF_TYPE:    walk.dtype = b;
        OFF_ADDRESS: begin
          walk.addr  = b;
          walk.ifnum = b;
        end
        OFF_ATTR:    walk.attr = b;
        OFF_SIZE_LO: walk.psize[7:0] = b;
        OFF_SIZE_HI: walk.psize[15:8] = b;
        default: ;
      endcase
      if (pos == OFF_LENGTH && b < HEADER_BYTES) begin
        walk.stopped = 1'b1;
      end else if (int'(pos) + 1 >= int'(walk.dlen)) begin
        // A descriptor takes effect only on its own final byte.
        if (walk.dtype == TYPE_ENDPOINT && walk.dlen >= MIN_EP_LENGTH) begin
          if (walk.attr == ATTR_BULK) begin
            ep_num = walk.addr & EP_NUM_MASK;
            if (walk.addr[DIR_IN_BIT]) begin
              walk.in_ep = ep_num[EPNUM_W-1:0];
              walk.in_sz = walk.psize;
            end else begin
              walk.out_ep = ep_num[EPNUM_W-1:0];
              walk.out_sz = walk.psize;
            end
          end
        end else if (walk.dtype == TYPE_INTERFACE && walk.dlen >= MIN_IF_LENGTH) begin
          walk.if_kept = walk.ifnum;
        end
        walk.pos = '0;
      end else begin
        walk.pos = pos + 8'd1;
      end
    end
    if (!last) return 1'b0;
    rpt.found             = (walk.in_ep != '0) || (walk.out_ep != '0);
    rpt.bulk_in_endpoint  = walk.in_ep;
    rpt.bulk_out_endpoint = walk.out_ep;
    rpt.in_max_packet     = walk.in_sz;
    rpt.out_max_packet    = walk.out_sz;
    rpt.interface_number  = walk.if_kept;
    clear_walk();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH report %0d %s: got 0x%0h, expected 0x%0h",
             report_index, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_report = result_t'(out_tdata[48:0]);
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report, found", 16'(got_report.found), 16'd0);
      end else begin
        want_report = expected_reports.pop_front();
        if (got_report.found !== want_report.found)
          report_mismatch("found", 16'(got_report.found), 16'(want_report.found));
        if (got_report.bulk_in_endpoint !== want_report.bulk_in_endpoint)
          report_mismatch("bulk_in_endpoint", 16'(got_report.bulk_in_endpoint),
                          16'(want_report.bulk_in_endpoint));
        if (got_report.bulk_out_endpoint !== want_report.bulk_out_endpoint)
          report_mismatch("bulk_out_endpoint", 16'(got_report.bulk_out_endpoint),
                          16'(want_report.bulk_out_endpoint));
        if (got_report.in_max_packet !== want_report.in_max_packet)
          report_mismatch("in_max_packet", got_report.in_max_packet,
                          want_report.in_max_packet);
        if (got_report.out_max_packet !== want_report.out_max_packet)
          report_mismatch("out_max_packet", got_report.out_max_packet,
                          want_report.out_max_packet);
        if (got_report.interface_number !== want_report.interface_number)
          report_mismatch("interface_number", 16'(got_report.interface_number),
                          16'(want_report.interface_number));
        if (out_tdata[55:49] !== 7'd0)
          report_mismatch("padding", 16'(out_tdata[55:49]), 16'd0);
      end
      report_index++;
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one byte; the prediction is made at the edge where the transaction completes.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    result_t rpt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (track_byte(b, last, rpt)) expected_reports.push_back(rpt);
  endtask

  task automatic send_blob();
    for (int i = 0; i < blob_bytes.size(); i++)
      send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
  endtask

  task automatic wait_reports_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  // Appends one descriptor, stopping after at most cut bytes.
  task automatic push_desc(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] typ,
                           input logic [BYTE_W-1:0] f2, input logic [BYTE_W-1:0] f3,
                           input logic [BYTE_W-1:0] f4, input logic [BYTE_W-1:0] f5,
                           input int cut);
    int span;
    span = (len < HEADER_BYTES) ? 1 : int'(len);
    if (span > cut) span = cut;
    for (int i = 0; i < span; i++) begin
      case (i)
        0: blob_bytes.push_back(len);
        1: blob_bytes.push_back(typ);
        2: blob_bytes.push_back(f2);
        3: blob_bytes.push_back(f3);
        4: blob_bytes.push_back(f4);
        5: blob_bytes.push_back(f5);
        default: blob_bytes.push_back(rand_byte());
      endcase
    end
  endtask

  task automatic build_random_blob();
    int n_desc;
    int pick;
    int keep;
    logic [BYTE_W-1:0] len;
    blob_bytes.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 8)) blob_bytes.push_back(rand_byte());
      return;
    end
    if ($urandom_range(99) < 60)
      push_desc(8'd9, DESC_CONFIG, rand_byte(), rand_byte(),
                rand_byte(), rand_byte(), FULL_SPAN);
    n_desc = $urandom_range(1, 3);
    for (int i = 0; i < n_desc; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = ($urandom_range(99) < 80) ? 8'd7 : 8'($urandom_range(2, 10));
        push_desc(len, TYPE_ENDPOINT, rand_byte(),
                  ($urandom_range(99) < 80) ? ATTR_BULK : rand_byte(),
                  rand_byte(), rand_byte(), FULL_SPAN);
      end else if (pick < 60) begin
        len = ($urandom_range(99) < 80) ? 8'd9 : 8'($urandom_range(2, 10));
        push_desc(len, TYPE_INTERFACE, rand_byte(), rand_byte(),
                  rand_byte(), rand_byte(), FULL_SPAN);
      end else if (pick < 85) begin
        push_desc(8'($urandom_range(2, 12)), rand_byte(), rand_byte(),
                  rand_byte(), rand_byte(), rand_byte(), FULL_SPAN);
      end else if (pick < 92) begin
        // A long descriptor that the blob always ends inside.
        push_desc(8'($urandom_range(13, 255)), rand_byte(), rand_byte(),
                  rand_byte(), rand_byte(), rand_byte(),
                  $urandom_range(2, 12));
        break;
      end else begin
        push_desc(8'($urandom_range(0, 1)), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, FULL_SPAN);
        repeat ($urandom_range(0, 6)) blob_bytes.push_back(rand_byte());
        break;
      end
    end
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(1, blob_bytes.size());
      while (blob_bytes.size() > keep) void'(blob_bytes.pop_back());
    end
  endtask

  task automatic test_single_byte_blob();
    blob_bytes = '{8'hFF};
    send_blob();
    blob_bytes = '{8'h01};
    send_blob();
  endtask

  task automatic test_bulk_endpoint_capture();
    // Shortest legal interface and endpoint bodies, then a standard OUT endpoint.
    blob_bytes = '{8'd3, TYPE_INTERFACE, 8'hAB,
                   8'd6, TYPE_ENDPOINT, 8'h8F, ATTR_BULK, 8'h00, 8'h00,
                   8'd7, TYPE_ENDPOINT, 8'h0F, ATTR_BULK, 8'hFF, 8'hFF, 8'h00};
    send_blob();
  endtask

  task automatic test_zero_length_stop();
    blob_bytes = '{8'h00, 8'd7, TYPE_ENDPOINT};
    send_blob();
  endtask

  task automatic test_cut_off_descriptor();
    blob_bytes = '{8'd7, TYPE_ENDPOINT, 8'h81, ATTR_BULK, 8'h20};
    send_blob();
    wait_reports_done();
  endtask

  task automatic test_random_blobs(input int s_pct, input int r_pct,
                                   input int byte_goal, input int blob_goal);
    int bytes_sent;
    int blobs_sent;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    bytes_sent = 0;
    blobs_sent = 0;
    while (bytes_sent < byte_goal || blobs_sent < blob_goal) begin
      build_random_blob();
      bytes_sent += blob_bytes.size();
      send_blob();
      blobs_sent++;
    end
    wait_reports_done();
  endtask

  initial begin
    clear_walk();
    send_idle_pct = 14;
    recv_idle_pct = 65;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte_blob();
    test_bulk_endpoint_capture();
    test_zero_length_stop();
    test_cut_off_descriptor();
    test_random_blobs(14, 65, 120, 6);
    test_random_blobs(65, 14, 120, 6);
    test_random_blobs(0, 0, 120, 6);
    repeat (10) @(posedge clk);
    if (expected_reports.size() != 0)
      report_mismatch("missing reports", 16'(expected_reports.size()), 16'd0);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
